[src/lfsr_kd_pkg.sv]
// Package for the keystream descrambler: generator state type, seeds,
// feedback masks and the single-bit generator step function.
// No dependencies.
`timescale 1ns / 1ps

package lfsr_kd_pkg;

   localparam int unsigned KEY_BITS  = 8;
   localparam int unsigned GEN_WIDTH = 16;

   // Seeds and feedback masks of the three shift registers
   localparam logic [GEN_WIDTH-1:0] SEED_A = 16'h2953;
   localparam logic [GEN_WIDTH-1:0] SEED_B = 16'hd9c2;
   localparam logic [GEN_WIDTH-1:0] SEED_C = 16'h3ff1;
   localparam logic [GEN_WIDTH-1:0] FB_A   = 16'ha740;
   localparam logic [GEN_WIDTH-1:0] FB_B   = 16'hfb10;
   localparam logic [GEN_WIDTH-1:0] FB_C   = 16'hb3d0;

   typedef struct packed {
      logic [GEN_WIDTH-1:0] gen_a;
      logic [GEN_WIDTH-1:0] gen_b;
      logic [GEN_WIDTH-1:0] gen_c;
      logic                 mix_bit;
   } gen_state_type;

   localparam gen_state_type SEED_STATE = '{
      gen_a:   SEED_A,
      gen_b:   SEED_B,
      gen_c:   SEED_C,
      mix_bit: 1'b1
   };

   // Control from the datapath to the keystream generator
   typedef struct packed {
      logic advance;  // consume one key byte
      logic reseed;   // item was last of its region: reload seeds
   } keygen_ctl_type;

   // One keystream bit: the new mix_bit is the output bit
   function automatic gen_state_type gen_step(input gen_state_type s);
      gen_state_type n;
      logic a0, a1, b0, b1, c0;
      a0 = s.gen_a[0];
      a1 = s.gen_a[1];
      b0 = s.gen_b[0];
      b1 = s.gen_b[1];
      c0 = s.gen_c[0];
      n.mix_bit = s.mix_bit ^ a1 ^ c0 ^ (b0 | b1) ^ ((a0 ^ b1 ^ c0) & (a0 ^ b0));
      n.gen_c = (a0 == b0) ? ((s.gen_c >> 1) ^ (c0 ? FB_C : '0)) : s.gen_c;
      n.gen_b = (!a0) ? ((s.gen_b >> 1) ^ (b0 ? FB_B : '0)) : s.gen_b;
      n.gen_a = (s.gen_a >> 1) ^ (a0 ? FB_A : '0);
      return n;
   endfunction

endpackage

[src/lfsr_kd_if.sv]
// Valid/ready channel interfaces for the descrambler's input and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface lfsr_kd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scrambled_byte;
   logic       last_byte;

   modport source (output valid, output scrambled_byte, output last_byte, input ready);
   modport sink   (input valid, input scrambled_byte, input last_byte, output ready);
endinterface

interface lfsr_kd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] plain_byte;
   logic       last_out;

   modport source (output valid, output plain_byte, output last_out, input ready);
   modport sink   (input valid, input plain_byte, input last_out, output ready);
endinterface

[src/lfsr_kd_keygen.sv]
// Keystream generator: three 16-bit shift registers and the mix bit,
// stepped eight times per key byte. Depends on lfsr_kd_pkg.
`timescale 1ns / 1ps

module lfsr_kd_keygen (
   input  logic                                clock,
   input  logic                                reset,
   input  lfsr_kd_pkg::keygen_ctl_type         ctl,
   output logic [lfsr_kd_pkg::KEY_BITS-1:0]    key_byte
);

   lfsr_kd_pkg::gen_state_type state_ff;
   lfsr_kd_pkg::gen_state_type state_in;
   lfsr_kd_pkg::gen_state_type stepped;

   // Eight chained steps; bits enter MSB first
   always_comb begin
      lfsr_kd_pkg::gen_state_type s;
      s = state_ff;
      for (int i = 0; i < lfsr_kd_pkg::KEY_BITS; i++) begin
         s = lfsr_kd_pkg::gen_step(s);
         key_byte[lfsr_kd_pkg::KEY_BITS-1-i] = s.mix_bit;
      end
      stepped = s;
   end

   // Next state: hold, advance, or reload seeds after a region's last item
   always_comb begin
      if (!ctl.advance) begin
         state_in = state_ff;
      end else if (ctl.reseed) begin
         state_in = lfsr_kd_pkg::SEED_STATE;
      end else begin
         state_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfsr_kd_pkg::SEED_STATE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !ctl.advance |=> $stable(state_ff))
      else $error("generator state moved without an advance");

   a_reseed: assert property (@(posedge clock) disable iff (reset)
      (ctl.advance && ctl.reseed) |=> (state_ff == lfsr_kd_pkg::SEED_STATE))
      else $error("generator not reseeded after last item");

   a_reset_seed: assert property (@(posedge clock)
      reset |=> (state_ff == lfsr_kd_pkg::SEED_STATE))
      else $error("generator not seeded by reset");

endmodule

[src/lfsr_keystream_descrambler.sv]
// Top level of the keystream descrambler: input register, keystream
// generator and result register. Depends on lfsr_kd_pkg, lfsr_kd_if, lfsr_kd_keygen.
//
// Usage:
//   req_chan carries scrambled bytes with a last_byte marker; rsp_chan
//   returns plain_byte = scrambled_byte ^ key byte, with last_out copying
//   the marker. Every accepted item yields exactly one result item, in order.
//   A result passes through the input register and then the result register.
//   Throughput: one item per cycle while the receiver takes results; the eight
//   generator steps for a key byte are one combinational chain between the input
//   register and the result register, so a key byte is ready as each item advances.
//   After the item marked last is passed on, the generator reloads its
//   seeds, so the next item starts a new region.
//   Reset (synchronous, active high) empties both registers and loads the
//   seeds. When the receiver stalls, the result register holds its item,
//   the input register takes one more item, and then req ready drops until
//   the result is taken.
`timescale 1ns / 1ps

module lfsr_keystream_descrambler (
   input logic           clock,
   input logic           reset,
   lfsr_kd_req_if.sink   req_chan,
   lfsr_kd_rsp_if.source rsp_chan
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_data_ff;
   logic       out_last_ff;
   logic       out_free;
   logic       advance;
   logic [lfsr_kd_pkg::KEY_BITS-1:0] key_byte;
   lfsr_kd_pkg::keygen_ctl_type      gen_ctl;

   // Handshake: the input item moves on when the result register is free
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   assign gen_ctl.advance = advance;
   assign gen_ctl.reseed  = in_last_ff;

   lfsr_kd_keygen u_keygen (
      .clock    (clock),
      .reset    (reset),
      .ctl      (gen_ctl),
      .key_byte (key_byte)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.scrambled_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (advance) begin
         out_data_ff <= in_data_ff ^ key_byte;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.plain_byte = out_data_ff;
   assign rsp_chan.last_out   = out_last_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> in_valid_ff)
      else $error("accepted item lost from input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)
                                     && $stable(in_last_ff)))
      else $error("input register changed while stalled");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item not in result register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !out_valid_ff))
      else $error("registers not empty after reset");

endmodule

[verif/lfsr_keystream_descrambler_tb.sv]
// Self-checking testbench for lfsr_keystream_descrambler: random valid/ready traffic
// on both channels, with results checked against an in-bench keystream predictor.
// Depends on lfsr_kd_pkg, lfsr_kd_if and the descrambler top level.
`timescale 1ns / 1ps

module lfsr_keystream_descrambler_tb;

   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned TAIL_ITEMS   = 80;    // final items sent without idling
   localparam int unsigned PRINT_CAP    = 30;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } scrambled_item_type;

   typedef struct packed {
      logic [7:0] plain;
      logic       last;
   } plain_item_type;

   logic clock;
   logic reset;

   lfsr_kd_req_if req_bus ();
   lfsr_kd_rsp_if rsp_bus ();

   lfsr_keystream_descrambler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   scrambled_item_type          pending_q[$];
   plain_item_type              expected_plain_q[$];
   lfsr_kd_pkg::gen_state_type  ks_state;

   logic        req_fire_seen;
   int unsigned req_gap;
   int unsigned rsp_gap;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned error_count;
   int unsigned items_accepted;
   int unsigned results_checked;
   int unsigned regions_closed;

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // One keystream bit per step; eight steps, MSB first, make a key byte
   function automatic logic [7:0] next_key_byte();
      logic [7:0] key;
      logic a0, a1, b0, b1, c0, m;
      key = '0;
      for (int i = 0; i < lfsr_kd_pkg::KEY_BITS; i++) begin
         a0 = ks_state.gen_a[0];
         a1 = ks_state.gen_a[1];
         b0 = ks_state.gen_b[0];
         b1 = ks_state.gen_b[1];
         c0 = ks_state.gen_c[0];
         m  = ks_state.mix_bit ^ a1 ^ c0 ^ (b0 | b1);
         m  = m ^ ((a0 ^ b1 ^ c0) & (a0 ^ b0));
         ks_state.mix_bit = m;
         // third register steps when the low bits of the first two agree
         if (a0 == b0)
            ks_state.gen_c = {1'b0, ks_state.gen_c[15:1]}
                             ^ ({16{c0}} & lfsr_kd_pkg::FB_C);
         // second register steps when the first's low bit is zero
         if (!a0)
            ks_state.gen_b = {1'b0, ks_state.gen_b[15:1]}
                             ^ ({16{b0}} & lfsr_kd_pkg::FB_B);
         ks_state.gen_a = {1'b0, ks_state.gen_a[15:1]} ^ ({16{a0}} & lfsr_kd_pkg::FB_A);
         key = {key[6:0], m};
      end
      return key;
   endfunction

   function automatic int unsigned pick_idle_pct();
      unique case ($urandom_range(3, 0))
         0: return 0;
         1: return 5;
         2: return 15;
         default: return 35;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (error_count < PRINT_CAP)
         $display("%0t ns: mismatch on %s: got 0x%02h, expected 0x%02h",
                  $time, what, got, want);
      error_count++;
   endtask

   task automatic queue_item(input logic [7:0] data, input logic last);
      scrambled_item_type it;
      it.data = data;
      it.last = last;
      pending_q.push_back(it);
   endtask

   // Driver: inputs change on the falling edge
   always @(negedge clock) begin : drive
      scrambled_item_type nxt;
      logic quiet_tail;
      quiet_tail = (pending_q.size() <= TAIL_ITEMS);
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         // input side: a new slot opens once the held item is taken
         if (!req_bus.valid || req_fire_seen) begin
            if (req_gap != 0 && !quiet_tail) begin
               req_bus.valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (!quiet_tail && $urandom_range(99, 0) < req_idle_pct) begin
               req_bus.valid <= 1'b0;
               req_gap <= $urandom_range(13, 0);
            end else if (pending_q.size() != 0) begin
               nxt = pending_q.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.scrambled_byte <= nxt.data;
               req_bus.last_byte      <= nxt.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
            if ($urandom_range(199, 0) == 0)
               req_idle_pct <= pick_idle_pct();
         end

         // result side: ready drops in bursts
         if (quiet_tail) begin
            rsp_bus.ready <= 1'b1;
            rsp_gap <= 0;
         end else if (rsp_gap != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else if ($urandom_range(99, 0) < rsp_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap <= $urandom_range(13, 0);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         if ($urandom_range(199, 0) == 0)
            rsp_idle_pct <= pick_idle_pct();
      end
   end

   // Monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin : watch
      plain_item_type want;
      plain_item_type got;
      logic [7:0]     key;
      if (reset) begin
         req_fire_seen <= 1'b0;
      end else begin
         req_fire_seen <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            key = next_key_byte();
            want.plain = req_bus.scrambled_byte ^ key;
            want.last  = req_bus.last_byte;
            expected_plain_q.push_back(want);
            items_accepted++;
            // region ends: generator starts over from its seeds
            if (req_bus.last_byte) begin
               ks_state = lfsr_kd_pkg::SEED_STATE;
               regions_closed++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.plain = rsp_bus.plain_byte;
            got.last  = rsp_bus.last_out;
            if (expected_plain_q.size() == 0) begin
               report_mismatch("unexpected result plain_byte", got.plain, 8'h00);
            end else begin
               want = expected_plain_q.pop_front();
               if (got.plain !== want.plain)
                  report_mismatch("plain_byte", got.plain, want.plain);
               if (got.last !== want.last)
                  report_mismatch("last_out", {7'b0, got.last}, {7'b0, want.last});
               results_checked++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      int unsigned len;
      int unsigned queued;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.scrambled_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      req_fire_seen = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      error_count = 0;
      items_accepted = 0;
      results_checked = 0;
      regions_closed = 0;
      ks_state = lfsr_kd_pkg::SEED_STATE;

      // directed: byte extremes, walking bits, short and back-to-back regions
      queue_item(8'h00, 1'b0);
      queue_item(8'hff, 1'b0);
      queue_item(8'haa, 1'b0);
      queue_item(8'h55, 1'b0);
      queue_item(8'h01, 1'b0);
      queue_item(8'h80, 1'b0);
      queue_item(8'hff, 1'b1);
      queue_item(8'h00, 1'b1);
      queue_item(8'hff, 1'b1);
      queue_item(8'h5a, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h7f, 1'b1);
      queue_item(8'h00, 1'b0);
      queue_item(8'hfe, 1'b0);

      // random: mostly whole regions, some stray items with a random marker
      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         if ($urandom_range(9, 0) == 0) begin
            queue_item(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            queued++;
         end else begin
            len = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 65)
                                               : $urandom_range(64, 1);
            for (int i = 1; i <= len; i++)
               queue_item(8'($urandom_range(255, 0)), i == len);
            queued += len;
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until every item is in and every result has come back
      while (pending_q.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_plain_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d results from %0d items over %0d completed regions,",
               results_checked, items_accepted, regions_closed);
      $display("with random idling on both channels and a final stretch at full rate.");
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #5_000_000;
      $display("Timeout with %0d results still outstanding", expected_plain_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
